// ===== rtl/scbc_pkg.sv =====
`default_nettype none

package scbc_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int SIZE_W  = 16;
  localparam int HDR_W   = 8;
  localparam int CLASS_W = 5;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_REFILL  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  localparam logic [HDR_W-1:0] HDR_RESET = 8'd16;

  // Size classes
  localparam int NUM_CLASSES = 20;
  localparam int MIN_BLOCK   = 32;
  localparam int MAX_BLOCK   = 4096;

  localparam int SMALL_LIMIT = 256;
  localparam int MID_LIMIT   = 1024;
  localparam int SMALL_STEP  = 32;
  localparam int MID_STEP    = 128;
  localparam int BIG_STEP    = 512;
  localparam int MID_BASE    = 8;
  localparam int BIG_BASE    = 14;

  // Parameter defaults for the top level
  localparam int STACK_DEPTH_DEF = 32;
  localparam int ADDR_WIDTH_DEF  = 32;

endpackage

`default_nettype wire

// ===== rtl/size_class_block_cache.sv =====
`default_nettype none

// Channel   Ports                                              Direction
// --------  -------------------------------------------------  ---------
// in        in_valid/in_stall, in_opcode, in_request_size,     in
//           in_block_address
// out       out_valid/out_stall, out_address, out_size_class,  out
//           out_accepted, out_class_count
// cfg       cfg_wr_en, cfg_wr_data (header_bytes)              in
//
// One item per cycle if out_stall is low; out_valid is stage 2's valid bit.
// The class is mapped on entry, then the stack slot is read or written in one
// pass through the per-class count and the single-port stack memory.
// Reset clears the class counts and sets header_bytes to 16; the stack memory
// is not cleared and needs no clearing pass.
// A stalled output holds its result; one more item waits in the stage behind
// it, and in_stall rises only when both are full and out_stall is high.

module size_class_block_cache #(
  parameter int STACK_DEPTH = scbc_pkg::STACK_DEPTH_DEF,
  parameter int ADDR_WIDTH  = scbc_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [scbc_pkg::OP_W-1:0]          in_opcode,
  input  wire logic [scbc_pkg::SIZE_W-1:0]        in_request_size,
  input  wire logic [ADDR_WIDTH-1:0]              in_block_address,

  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [ADDR_WIDTH-1:0]              out_address,
  output logic      [scbc_pkg::CLASS_W-1:0]       out_size_class,
  output logic                                    out_accepted,
  output logic      [$clog2(STACK_DEPTH+1)-1:0]   out_class_count,

  input  wire logic                               cfg_wr_en,
  input  wire logic [scbc_pkg::HDR_W-1:0]         cfg_wr_data
);

  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MEM_D    = scbc_pkg::NUM_CLASSES * STACK_DEPTH;
  localparam int MEM_AW   = $clog2(MEM_D);
  localparam int SUM_W    = scbc_pkg::SIZE_W + 1;

  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(STACK_DEPTH);
  localparam logic [MEM_AW-1:0] DEPTH_M = MEM_AW'(STACK_DEPTH);

  // Configuration
  logic [scbc_pkg::HDR_W-1:0] header_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= scbc_pkg::HDR_RESET;
    end else if (cfg_wr_en) begin
      header_r <= cfg_wr_data;
    end
  end

  // Entry: add the header where it applies and map to a class
  logic                          add_hdr;
  logic [SUM_W-1:0]              sum;
  logic [scbc_pkg::CLASS_W-1:0]  in_class;

  assign add_hdr = (in_opcode == scbc_pkg::OP_ALLOC) || (in_opcode == scbc_pkg::OP_REFILL);
  assign sum     = SUM_W'(in_request_size) + (add_hdr ? SUM_W'(header_r) : SUM_W'(0));

  scbc_size_class u_size_class (
    .size       (sum),
    .size_class (in_class)
  );

  // Stage 1: class, opcode, address
  logic                          s1_v_r;
  logic [scbc_pkg::OP_W-1:0]     s1_op_r;
  logic [scbc_pkg::CLASS_W-1:0]  s1_cls_r;
  logic [ADDR_WIDTH-1:0]         s1_addr_r;

  logic                          s2_load;
  logic                          s1_adv;
  logic                          s1_load;

  assign s2_load  = !out_valid || !out_stall;
  assign s1_adv   = s1_v_r && s2_load;
  assign in_stall = s1_v_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r   <= in_opcode;
      s1_cls_r  <= in_class;
      s1_addr_r <= in_block_address;
    end
  end

  // Class counts and stack access
  logic [CNT_W-1:0]  counts_r [scbc_pkg::NUM_CLASSES];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  slot_cnt;
  logic              is_alloc;
  logic              is_push;
  logic              hit;
  logic              push_ok;
  logic [MEM_AW-1:0] mem_addr;

  assign cnt      = counts_r[s1_cls_r];
  assign is_alloc = (s1_op_r == scbc_pkg::OP_ALLOC);
  assign is_push  = (s1_op_r == scbc_pkg::OP_RELEASE) || (s1_op_r == scbc_pkg::OP_REFILL);
  assign hit      = is_alloc && (cnt != '0);
  assign push_ok  = is_push && (cnt < DEPTH_C);

  always_comb begin
    if (hit) begin
      cnt_nxt  = cnt - CNT_W'(1);
      slot_cnt = cnt - CNT_W'(1);
    end else if (push_ok) begin
      cnt_nxt  = cnt + CNT_W'(1);
      slot_cnt = cnt;
    end else begin
      cnt_nxt  = cnt;
      slot_cnt = cnt;
    end
  end

  assign mem_addr = MEM_AW'(s1_cls_r) * DEPTH_M + MEM_AW'(slot_cnt[PTR_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scbc_pkg::NUM_CLASSES; i++) begin
        counts_r[i] <= '0;
      end
    end else if (s1_adv) begin
      counts_r[s1_cls_r] <= cnt_nxt;
    end
  end

  logic [ADDR_WIDTH-1:0] stack_mem [MEM_D];
  logic [ADDR_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (s1_adv && push_ok) begin
      stack_mem[mem_addr] <= s1_addr_r;
    end
    if (s1_adv && hit) begin
      rd_data_r <= stack_mem[mem_addr];
    end
  end

  // Stage 2: result register
  logic                          s2_v_r;
  logic                          s2_hit_r;
  logic                          s2_acc_r;
  logic [scbc_pkg::CLASS_W-1:0]  s2_cls_r;
  logic [CNT_W-1:0]              s2_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_hit_r <= hit;
      s2_acc_r <= hit || push_ok;
      s2_cls_r <= s1_cls_r;
      s2_cnt_r <= cnt_nxt;
    end
  end

  assign out_valid       = s2_v_r;
  assign out_address     = s2_hit_r ? rd_data_r : '0;
  assign out_size_class  = s2_cls_r;
  assign out_accepted    = s2_acc_r;
  assign out_class_count = s2_cnt_r;

endmodule

`default_nettype wire

// ===== rtl/scbc_size_class.sv =====
`default_nettype none

module scbc_size_class (
  input  wire logic [scbc_pkg::SIZE_W:0]      size,
  output logic      [scbc_pkg::CLASS_W-1:0]   size_class
);

  localparam int SUM_W   = scbc_pkg::SIZE_W + 1;
  localparam int CLAMP_W = $clog2(scbc_pkg::MAX_BLOCK + 1);

  localparam int SMALL_SH = $clog2(scbc_pkg::SMALL_STEP);
  localparam int MID_SH   = $clog2(scbc_pkg::MID_STEP);
  localparam int BIG_SH   = $clog2(scbc_pkg::BIG_STEP);

  localparam logic [SUM_W-1:0]   MIN_S = SUM_W'(scbc_pkg::MIN_BLOCK);
  localparam logic [SUM_W-1:0]   MAX_S = SUM_W'(scbc_pkg::MAX_BLOCK);
  localparam logic [CLAMP_W-1:0] SMALL_LIM = CLAMP_W'(scbc_pkg::SMALL_LIMIT);
  localparam logic [CLAMP_W-1:0] MID_LIM   = CLAMP_W'(scbc_pkg::MID_LIMIT);
  localparam logic [CLAMP_W-1:0] MID_OFS   = CLAMP_W'(scbc_pkg::SMALL_LIMIT + 1);
  localparam logic [CLAMP_W-1:0] BIG_OFS   = CLAMP_W'(scbc_pkg::MID_LIMIT + 1);
  localparam logic [scbc_pkg::CLASS_W-1:0] MID_BASE_C =
      scbc_pkg::CLASS_W'(scbc_pkg::MID_BASE);
  localparam logic [scbc_pkg::CLASS_W-1:0] BIG_BASE_C =
      scbc_pkg::CLASS_W'(scbc_pkg::BIG_BASE);
  localparam logic [scbc_pkg::CLASS_W-1:0] TOP_CLASS =
      scbc_pkg::CLASS_W'(scbc_pkg::NUM_CLASSES - 1);

  logic [CLAMP_W-1:0]            clamped;
  logic [CLAMP_W-1:0]            d_small;
  logic [CLAMP_W-1:0]            d_mid;
  logic [CLAMP_W-1:0]            d_big;
  logic [scbc_pkg::CLASS_W-1:0]  raw_class;

  always_comb begin
    if (size < MIN_S) begin
      clamped = CLAMP_W'(scbc_pkg::MIN_BLOCK);
    end else if (size > MAX_S) begin
      clamped = CLAMP_W'(scbc_pkg::MAX_BLOCK);
    end else begin
      clamped = size[CLAMP_W-1:0];
    end

    d_small = clamped - CLAMP_W'(1);
    d_mid   = clamped - MID_OFS;
    d_big   = clamped - BIG_OFS;

    if (clamped <= SMALL_LIM) begin
      raw_class = scbc_pkg::CLASS_W'(d_small >> SMALL_SH);
    end else if (clamped <= MID_LIM) begin
      raw_class = MID_BASE_C + scbc_pkg::CLASS_W'(d_mid >> MID_SH);
    end else begin
      raw_class = BIG_BASE_C + scbc_pkg::CLASS_W'(d_big >> BIG_SH);
    end

    size_class = (raw_class > TOP_CLASS) ? TOP_CLASS : raw_class;
  end

endmodule

`default_nettype wire

// ===== test/tb_size_class_block_cache.sv =====
module tb_size_class_block_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import scbc_pkg::*;

  localparam int DEPTH    = STACK_DEPTH_DEF;
  localparam int AW       = ADDR_WIDTH_DEF;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int HOLD_LEN = 300;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size;
    logic [AW-1:0]     addr;
  } cache_req_t;

  typedef struct packed {
    logic [AW-1:0]      addr;
    logic [CLASS_W-1:0] cls;
    logic               ok;
    logic [CNT_W-1:0]   count;
  } cache_resp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid         = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode        = OP_NOP;
  logic [SIZE_W-1:0] in_request_size  = '0;
  logic [AW-1:0]     in_block_address = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [AW-1:0]      out_address;
  logic [CLASS_W-1:0] out_size_class;
  logic               out_accepted;
  logic [CNT_W-1:0]   out_class_count;

  logic             cfg_wr_en   = 1'b0;
  logic [HDR_W-1:0] cfg_wr_data = '0;

  // Shadow of the block state
  logic [HDR_W-1:0] hdr_bytes = HDR_RESET;
  logic [AW-1:0]    block_stack [NUM_CLASSES][DEPTH];
  int unsigned      fill [NUM_CLASSES] = '{default: 0};

  cache_req_t  req_q[$];
  cache_resp_t resp_q[$];

  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  bit  in_took       = 1'b0;
  bit  long_hold     = 1'b0;
  int  errors        = 0;
  event hold_trig;

  size_class_block_cache dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_request_size  (in_request_size),
    .in_block_address (in_block_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_address      (out_address),
    .out_size_class   (out_size_class),
    .out_accepted     (out_accepted),
    .out_class_count  (out_class_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned class_of_size(int unsigned total);
    int unsigned s;
    s = total;
    if (s < MIN_BLOCK) s = MIN_BLOCK;
    if (s > MAX_BLOCK) s = MAX_BLOCK;
    if (s <= SMALL_LIMIT) return (s - 1) / SMALL_STEP;
    if (s <= MID_LIMIT) return MID_BASE + (s - SMALL_LIMIT - 1) / MID_STEP;
    return BIG_BASE + (s - MID_LIMIT - 1) / BIG_STEP;
  endfunction

  // Apply one request to the shadow stacks and return the response it yields.
  function automatic cache_resp_t run_cache_op(cache_req_t r);
    int unsigned total;
    int unsigned c;
    cache_resp_t e;
    total = r.size;
    if (r.op == OP_ALLOC || r.op == OP_REFILL) total += hdr_bytes;
    c = class_of_size(total);
    e = '0;
    e.cls = CLASS_W'(c);
    case (r.op)
      OP_ALLOC: begin
        if (fill[c] > 0) begin
          fill[c]--;
          e.addr = block_stack[c][fill[c]];
          e.ok = 1'b1;
        end
      end
      OP_RELEASE, OP_REFILL: begin
        if (fill[c] < DEPTH) begin
          block_stack[c][fill[c]] = r.addr;
          fill[c]++;
          e.ok = 1'b1;
        end
      end
      default: ;
    endcase
    e.count = CNT_W'(fill[c]);
    return e;
  endfunction

  // Pick a class in [c_lo, c_hi] and a size inside it, often on its edges.
  function automatic cache_req_t make_req(int push_pct, int c_lo, int c_hi);
    cache_req_t r;
    int unsigned pick, c, lo, hi, s;
    pick = $urandom_range(99);
    if (pick < 4) r.op = OP_NOP;
    else if (pick < 4 + push_pct) r.op = $urandom_range(1) ? OP_RELEASE : OP_REFILL;
    else r.op = OP_ALLOC;
    r.addr = $urandom;
    if ($urandom_range(9) == 0) begin
      r.size = SIZE_W'($urandom);
      return r;
    end
    c = $urandom_range(c_hi, c_lo);
    if (c < MID_BASE) begin
      lo = (c == 0) ? 0 : c * SMALL_STEP + 1;
      hi = (c + 1) * SMALL_STEP;
    end else if (c < BIG_BASE) begin
      lo = SMALL_LIMIT + 1 + (c - MID_BASE) * MID_STEP;
      hi = lo + MID_STEP - 1;
    end else begin
      lo = MID_LIMIT + 1 + (c - BIG_BASE) * BIG_STEP;
      hi = (c == NUM_CLASSES - 1) ? 65535 : lo + BIG_STEP - 1;
    end
    case ($urandom_range(3))
      0:       s = lo;
      1:       s = hi;
      default: s = $urandom_range(hi, lo);
    endcase
    if (r.op == OP_RELEASE || r.op == OP_NOP) r.size = SIZE_W'(s);
    else r.size = (s > hdr_bytes) ? SIZE_W'(s - hdr_bytes) : '0;
    return r;
  endfunction

  // Driver: advance to the next request once the current one transferred.
  always @(negedge clk) begin
    cache_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        in_valid         <= 1'b1;
        in_opcode        <= nxt.op;
        in_request_size  <= nxt.size;
        in_block_address <= nxt.addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= long_hold || ($urandom_range(99) < stall_pct);
  end

  // Hold the output off for a long stretch while requests keep coming.
  always begin
    @(hold_trig);
    long_hold = 1'b1;
    repeat (HOLD_LEN) @(negedge clk);
    long_hold = 1'b0;
  end

  // Monitor: check response transfers, then predict from request transfers.
  always @(posedge clk) begin
    cache_resp_t want;
    cache_resp_t got;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{addr: out_address, cls: out_size_class, ok: out_accepted,
                count: out_class_count};
        if (resp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected response addr=%h class=%0d acc=%0d count=%0d",
                   $time, got.addr, got.cls, got.ok, got.count);
        end else begin
          want = resp_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected addr=%h class=%0d acc=%0d count=%0d",
                     $time, want.addr, want.cls, want.ok, want.count);
            $display("%0t:          actual   addr=%h class=%0d acc=%0d count=%0d",
                     $time, got.addr, got.cls, got.ok, got.count);
          end
        end
      end
      if (in_valid && !in_stall)
        resp_q.insert(resp_q.size(), run_cache_op('{op: in_opcode, size: in_request_size,
                                                    addr: in_block_address}));
    end
  end

  task automatic queue_req(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                           logic [AW-1:0] addr);
    req_q.insert(req_q.size(), '{op: op, size: size, addr: addr});
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || resp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_header(logic [HDR_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    hdr_bytes = v;
  endtask

  task automatic run_phase(logic [HDR_W-1:0] hdr, int idle_p, int stall_p, int n,
                           int push_pct, int c_lo, int c_hi, bit with_hold);
    write_header(hdr);
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    repeat (n) req_q.insert(req_q.size(), make_req(push_pct, c_lo, c_hi));
    if (with_hold) -> hold_trig;
    wait_drained();
  endtask

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Edges of the size map, saturation, header sum and unused opcode
    queue_req(OP_ALLOC,   16'd0,     32'h0);
    queue_req(OP_RELEASE, 16'd0,     32'hFFFF_FFFF);
    queue_req(OP_RELEASE, 16'd32,    32'h0);
    queue_req(OP_ALLOC,   16'd16,    32'h1111_1111);
    queue_req(OP_ALLOC,   16'd0,     32'h2222_2222);
    queue_req(OP_REFILL,  16'hFFFF,  32'hA5A5_A5A5);
    queue_req(OP_RELEASE, 16'd4096,  32'h5A5A_5A5A);
    queue_req(OP_RELEASE, 16'd4097,  32'h1234_5678);
    queue_req(OP_RELEASE, 16'd256,   32'h0000_0100);
    queue_req(OP_RELEASE, 16'd257,   32'h0000_0101);
    queue_req(OP_RELEASE, 16'd1024,  32'h0000_0400);
    queue_req(OP_RELEASE, 16'd1025,  32'h0000_0401);
    queue_req(OP_RELEASE, 16'd33,    32'h0000_0021);
    queue_req(OP_NOP,     16'hFFFF,  32'hFFFF_FFFF);
    queue_req(OP_NOP,     16'd0,     32'h0);
    queue_req(OP_ALLOC,   16'hFFFF,  32'h0);
    queue_req(OP_ALLOC,   16'd240,   32'h0);
    queue_req(OP_ALLOC,   16'd241,   32'h0);
    queue_req(OP_ALLOC,   16'd1008,  32'h0);
    queue_req(OP_ALLOC,   16'd1009,  32'h0);
    queue_req(OP_ALLOC,   16'd17,    32'h0);
    queue_req(OP_REFILL,  16'd0,     32'hFFFF_0000);
    wait_drained();

    // Push-heavy on a few classes to fill stacks and spill, then mixed random phases
    run_phase(8'd0,        0,  0, 330, 75, 0, 3, 1'b0);
    run_phase(8'd255,     59,  0, 330, 25, 0, NUM_CLASSES - 1, 1'b0);
    run_phase(8'h55,       0, 59, 330, 48, 0, NUM_CLASSES - 1, 1'b0);
    run_phase(8'hAA,      13, 13, 330, 50, NUM_CLASSES - 3, NUM_CLASSES - 1, 1'b0);
    run_phase(HDR_W'($urandom), 0, 0, 300, 50, 5, 9, 1'b1);

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
